/* hw/rtl/ll1p_pkg.sv */
// ll1p_pkg: symbol codes, grammar rules and the parse table for the ll(1) parser
// no dependencies; FIRST/FOLLOW sets and the table are computed at elaboration
package ll1p_pkg;

    localparam int NT_BASE    = 32;
    localparam int NT_COUNT   = 33;
    localparam int PROD_COUNT = 64;
    localparam int MAX_RHS    = 10;
    localparam int SYM_W      = 7;
    localparam int TOK_W      = 6;
    localparam int CNT_W      = 6;
    localparam int TOTAL_W    = 16;
    localparam int EPS        = 32;
    localparam int PASSES     = 2 * NT_COUNT;

    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [TOK_W-1:0] tok_t;

    // terminals
    localparam sym_t T_IDENT  = 7'd0;
    localparam sym_t T_NUMBER = 7'd1;
    localparam sym_t T_KPROG  = 7'd2;
    localparam sym_t T_KVAR   = 7'd3;
    localparam sym_t T_KARRAY = 7'd4;
    localparam sym_t T_KOF    = 7'd5;
    localparam sym_t T_KINT   = 7'd6;
    localparam sym_t T_KREAL  = 7'd7;
    localparam sym_t T_KFUNC  = 7'd8;
    localparam sym_t T_KPROC  = 7'd9;
    localparam sym_t T_KBEGIN = 7'd10;
    localparam sym_t T_KEND   = 7'd11;
    localparam sym_t T_KIF    = 7'd12;
    localparam sym_t T_KTHEN  = 7'd13;
    localparam sym_t T_KELSE  = 7'd14;
    localparam sym_t T_KWHILE = 7'd15;
    localparam sym_t T_KDO    = 7'd16;
    localparam sym_t T_KNOT   = 7'd17;
    localparam sym_t T_ASSIGN = 7'd18;
    localparam sym_t T_REL    = 7'd19;
    localparam sym_t T_ADD    = 7'd20;
    localparam sym_t T_MUL    = 7'd21;
    localparam sym_t T_LPAR   = 7'd22;
    localparam sym_t T_RPAR   = 7'd23;
    localparam sym_t T_LBRK   = 7'd24;
    localparam sym_t T_RBRK   = 7'd25;
    localparam sym_t T_COMMA  = 7'd26;
    localparam sym_t T_SEMI   = 7'd27;
    localparam sym_t T_COLON  = 7'd28;
    localparam sym_t T_PERIOD = 7'd29;
    localparam sym_t T_RANGE  = 7'd30;
    localparam sym_t T_EOI    = 7'd31;

    localparam tok_t TOK_EOI     = 6'd31;
    localparam tok_t TOK_UNKNOWN = 6'd32;

    // nonterminals
    localparam sym_t N_PROG  = 7'd32;
    localparam sym_t N_IDL   = 7'd33;
    localparam sym_t N_IDLT  = 7'd34;
    localparam sym_t N_DECLS = 7'd35;
    localparam sym_t N_DL    = 7'd36;
    localparam sym_t N_DLT   = 7'd37;
    localparam sym_t N_TYPE  = 7'd38;
    localparam sym_t N_STD   = 7'd39;
    localparam sym_t N_SUBS  = 7'd40;
    localparam sym_t N_SUB   = 7'd41;
    localparam sym_t N_SHEAD = 7'd42;
    localparam sym_t N_ARGS  = 7'd43;
    localparam sym_t N_PL    = 7'd44;
    localparam sym_t N_PT    = 7'd45;
    localparam sym_t N_COMP  = 7'd46;
    localparam sym_t N_OPTS  = 7'd47;
    localparam sym_t N_SL    = 7'd48;
    localparam sym_t N_SLT   = 7'd49;
    localparam sym_t N_SLTS  = 7'd50;
    localparam sym_t N_STMT  = 7'd51;
    localparam sym_t N_SIT   = 7'd52;
    localparam sym_t N_ELSE  = 7'd53;
    localparam sym_t N_ELO   = 7'd54;
    localparam sym_t N_EL    = 7'd55;
    localparam sym_t N_ELT   = 7'd56;
    localparam sym_t N_EXPR  = 7'd57;
    localparam sym_t N_EXT   = 7'd58;
    localparam sym_t N_SIMP  = 7'd59;
    localparam sym_t N_SIMT  = 7'd60;
    localparam sym_t N_TERM  = 7'd61;
    localparam sym_t N_TERMT = 7'd62;
    localparam sym_t N_FACT  = 7'd63;
    localparam sym_t N_FIT   = 7'd64;

    typedef struct packed {
        sym_t                           lhs;
        logic [3:0]                     len;
        logic [MAX_RHS-1:0][SYM_W-1:0]  rhs;
    } rule_t;

    // item from the front end to the back end
    typedef struct packed {
        tok_t tok;
    } item_t;

    // channel payloads seen on the ports
    typedef struct packed {
        tok_t token_class;
    } token_t;

    typedef struct packed {
        logic             token_matched;
        logic             token_discarded;
        logic [CNT_W-1:0] errors_added;
        logic [CNT_W-1:0] expansions_done;
        logic             parse_accepted;
        logic             parse_clean;
        logic             stack_overflowed;
    } result_t;

    typedef logic [32:0]                     tset_t;
    typedef logic [NT_COUNT-1:0][32:0]       tsets_t;
    typedef logic [NT_COUNT-1:0][31:0][6:0]  ptab_t;

    function automatic rule_t mk(sym_t l, int n,
                                 sym_t s0 = '0, sym_t s1 = '0, sym_t s2 = '0,
                                 sym_t s3 = '0, sym_t s4 = '0, sym_t s5 = '0,
                                 sym_t s6 = '0, sym_t s7 = '0, sym_t s8 = '0,
                                 sym_t s9 = '0);
        rule_t r;
        r.lhs    = l;
        r.len    = 4'(n);
        r.rhs[0] = s0;
        r.rhs[1] = s1;
        r.rhs[2] = s2;
        r.rhs[3] = s3;
        r.rhs[4] = s4;
        r.rhs[5] = s5;
        r.rhs[6] = s6;
        r.rhs[7] = s7;
        r.rhs[8] = s8;
        r.rhs[9] = s9;
        return r;
    endfunction

    function automatic rule_t rule_at(int p);
        case (p)
            0:  return mk(N_PROG, 10, T_KPROG, T_IDENT, T_LPAR, N_IDL, T_RPAR, T_SEMI,
                          N_DECLS, N_SUBS, N_COMP, T_PERIOD);
            1:  return mk(N_IDL, 2, T_IDENT, N_IDLT);
            2:  return mk(N_IDLT, 3, T_COMMA, T_IDENT, N_IDLT);
            3:  return mk(N_IDLT, 0);
            4:  return mk(N_DECLS, 3, T_KVAR, N_DL, N_DECLS);
            5:  return mk(N_DECLS, 0);
            6:  return mk(N_DL, 6, T_IDENT, N_IDLT, T_COLON, N_TYPE, T_SEMI, N_DLT);
            7:  return mk(N_DLT, 6, T_IDENT, N_IDLT, T_COLON, N_TYPE, T_SEMI, N_DLT);
            8:  return mk(N_DLT, 0);
            9:  return mk(N_TYPE, 1, N_STD);
            10: return mk(N_TYPE, 8, T_KARRAY, T_LBRK, T_NUMBER, T_RANGE, T_NUMBER,
                          T_RBRK, T_KOF, N_STD);
            11: return mk(N_STD, 1, T_KINT);
            12: return mk(N_STD, 1, T_KREAL);
            13: return mk(N_SUBS, 3, N_SUB, T_SEMI, N_SUBS);
            14: return mk(N_SUBS, 0);
            15: return mk(N_SUB, 3, N_SHEAD, N_DECLS, N_COMP);
            16: return mk(N_SHEAD, 6, T_KFUNC, T_IDENT, N_ARGS, T_COLON, N_STD, T_SEMI);
            17: return mk(N_SHEAD, 4, T_KPROC, T_IDENT, N_ARGS, T_SEMI);
            18: return mk(N_ARGS, 3, T_LPAR, N_PL, T_RPAR);
            19: return mk(N_ARGS, 0);
            20: return mk(N_PL, 4, N_IDL, T_COLON, N_TYPE, N_PT);
            21: return mk(N_PT, 5, T_SEMI, N_IDL, T_COLON, N_TYPE, N_PT);
            22: return mk(N_PT, 0);
            23: return mk(N_COMP, 3, T_KBEGIN, N_OPTS, T_KEND);
            24: return mk(N_OPTS, 1, N_SL);
            25: return mk(N_OPTS, 0);
            26: return mk(N_SL, 2, N_STMT, N_SLT);
            27: return mk(N_SLT, 2, T_SEMI, N_SLTS);
            28: return mk(N_SLT, 0);
            29: return mk(N_SLTS, 2, N_STMT, N_SLT);
            30: return mk(N_SLTS, 0);
            31: return mk(N_STMT, 2, T_IDENT, N_SIT);
            32: return mk(N_STMT, 1, N_COMP);
            33: return mk(N_STMT, 5, T_KIF, N_EXPR, T_KTHEN, N_STMT, N_ELSE);
            34: return mk(N_STMT, 4, T_KWHILE, N_EXPR, T_KDO, N_STMT);
            35: return mk(N_STMT, 0);
            36: return mk(N_SIT, 2, T_ASSIGN, N_EXPR);
            37: return mk(N_SIT, 5, T_LBRK, N_EXPR, T_RBRK, T_ASSIGN, N_EXPR);
            38: return mk(N_SIT, 3, T_LPAR, N_ELO, T_RPAR);
            39: return mk(N_SIT, 0);
            40: return mk(N_ELSE, 2, T_KELSE, N_STMT);
            41: return mk(N_ELSE, 0);
            42: return mk(N_ELO, 1, N_EL);
            43: return mk(N_ELO, 0);
            44: return mk(N_EL, 2, N_EXPR, N_ELT);
            45: return mk(N_ELT, 3, T_COMMA, N_EXPR, N_ELT);
            46: return mk(N_ELT, 0);
            47: return mk(N_EXPR, 2, N_SIMP, N_EXT);
            48: return mk(N_EXT, 2, T_REL, N_SIMP);
            49: return mk(N_EXT, 0);
            50: return mk(N_SIMP, 3, T_ADD, N_TERM, N_SIMT);
            51: return mk(N_SIMP, 2, N_TERM, N_SIMT);
            52: return mk(N_SIMT, 3, T_ADD, N_TERM, N_SIMT);
            53: return mk(N_SIMT, 0);
            54: return mk(N_TERM, 2, N_FACT, N_TERMT);
            55: return mk(N_TERMT, 3, T_MUL, N_FACT, N_TERMT);
            56: return mk(N_TERMT, 0);
            57: return mk(N_FACT, 2, T_IDENT, N_FIT);
            58: return mk(N_FACT, 1, T_NUMBER);
            59: return mk(N_FACT, 3, T_LPAR, N_EXPR, T_RPAR);
            60: return mk(N_FACT, 2, T_KNOT, N_FACT);
            61: return mk(N_FIT, 3, T_LPAR, N_ELO, T_RPAR);
            62: return mk(N_FIT, 3, T_LBRK, N_EXPR, T_RBRK);
            63: return mk(N_FIT, 0);
            default: return '0;
        endcase
    endfunction

    function automatic tset_t seq_first(rule_t r, int from, tsets_t fs);
        tset_t acc;
        int    s;
        acc = '0;
        for (int i = from; i < int'(r.len); i++) begin
            s = int'(r.rhs[i]);
            if (s < NT_BASE) begin
                return acc | (tset_t'(1) << s);
            end
            acc = acc | (fs[s - NT_BASE] & ~(tset_t'(1) << EPS));
            if (!fs[s - NT_BASE][EPS]) begin
                return acc;
            end
        end
        return acc | (tset_t'(1) << EPS);
    endfunction

    function automatic tsets_t calc_first();
        tsets_t fs;
        rule_t  r;
        fs = '0;
        for (int pass = 0; pass < PASSES; pass++) begin
            for (int p = 0; p < PROD_COUNT; p++) begin
                r = rule_at(p);
                fs[int'(r.lhs) - NT_BASE] = fs[int'(r.lhs) - NT_BASE] | seq_first(r, 0, fs);
            end
        end
        return fs;
    endfunction

    function automatic tsets_t calc_follow(tsets_t fs);
        tsets_t fo;
        rule_t  r;
        tset_t  fb;
        int     s;
        int     l;
        fo = '0;
        fo[0] = tset_t'(1) << int'(T_EOI);
        for (int pass = 0; pass < PASSES; pass++) begin
            for (int p = 0; p < PROD_COUNT; p++) begin
                r = rule_at(p);
                l = int'(r.lhs) - NT_BASE;
                for (int i = 0; i < int'(r.len); i++) begin
                    s = int'(r.rhs[i]);
                    if (s >= NT_BASE) begin
                        fb = seq_first(r, i + 1, fs);
                        fo[s - NT_BASE] = fo[s - NT_BASE] | (fb & ~(tset_t'(1) << EPS));
                        if (fb[EPS]) begin
                            fo[s - NT_BASE] = fo[s - NT_BASE] | fo[l];
                        end
                    end
                end
            end
        end
        return fo;
    endfunction

    // later first entries overwrite, follow entries fill only empty cells
    function automatic ptab_t calc_ptable(tsets_t fs, tsets_t fo);
        ptab_t pt;
        rule_t r;
        tset_t f;
        int    l;
        pt = '0;
        for (int p = 0; p < PROD_COUNT; p++) begin
            r = rule_at(p);
            l = int'(r.lhs) - NT_BASE;
            f = seq_first(r, 0, fs);
            for (int t = 0; t < 32; t++) begin
                if (f[t]) begin
                    pt[l][t] = 7'(p + 1);
                end
            end
            if (f[EPS]) begin
                for (int t = 0; t < 32; t++) begin
                    if (fo[l][t] && pt[l][t] == 7'd0) begin
                        pt[l][t] = 7'(p + 1);
                    end
                end
            end
        end
        return pt;
    endfunction

    localparam tsets_t FIRST_SETS  = calc_first();
    localparam tsets_t FOLLOW_SETS = calc_follow(FIRST_SETS);
    localparam ptab_t  PTABLE      = calc_ptable(FIRST_SETS, FOLLOW_SETS);

endpackage

/* hw/rtl/ll1p_stream_if.sv */
// ll1p_stream_if: valid/ready channel with a typed payload
// no dependencies; the payload type is set per instance
interface ll1p_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/ll1_table_parser_with_recovery_unit.sv */
// ll1_table_parser_with_recovery_unit: top level of the table-driven ll(1) parser
// depends on ll1p_pkg, ll1p_stream_if, ll1p_front and ll1p_back
//
// One token class goes in per transaction and exactly one result transaction
// comes out for it, in order. The front end takes tokens into a two-entry queue
// while the back end works, so a waiting result never blocks token intake until
// the queue fills. The back end does one stack operation per cycle on a
// single-write stack memory with a registered read. A table lookup passes the
// LOOK and DECIDE states and each pushed symbol is written in the PUSH state. A
// terminal pop is the pop plus a memory read. A nonterminal popped in recovery,
// or an expansion to an empty right-hand side, is a lookup plus a memory read.
// Taking the token and posting the result have their own states, and a token
// first passes the front queue. Once the parse is accepted or the stack
// overflows, each later token returns an all-zero result until reset. The
// stack needs no clearing pass.
module ll1_table_parser_with_recovery_unit
    import ll1p_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    ll1p_stream_if.sink   tokens,
    ll1p_stream_if.source results
);

    // queue between the token front end and the stack sequencer
    ll1p_stream_if #(.payload_t(item_t)) items ();

    ll1p_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .tokens (tokens),
        .items  (items)
    );

    ll1p_back #(.STACK_DEPTH(STACK_DEPTH)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    // a token is either matched or discarded, never both
    a_match_excl: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> !(results.payload.token_matched && results.payload.token_discarded))
        else $error("token both matched and discarded");

    // a clean parse is always an accepted one
    a_clean_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.payload.parse_clean) |-> results.payload.parse_accepted)
        else $error("clean without accept");

    // accept and overflow end the parse and exclude consuming the token
    a_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.payload.parse_accepted ||
                           results.payload.stack_overflowed))
        |-> !(results.payload.token_matched || results.payload.token_discarded))
        else $error("terminal result also consumed token");

endmodule

/* hw/rtl/ll1p_front.sv */
// ll1p_front: accepts token transactions, maps unknown classes, queues two items
// depends on ll1p_pkg and ll1p_stream_if
module ll1p_front
    import ll1p_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ll1p_stream_if.sink   tokens,
    ll1p_stream_if.source items
);

    item_t      q_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;
    item_t      cls;

    assign tokens.ready  = (cnt_reg != 2'd2);
    assign items.valid   = (cnt_reg != 2'd0);
    assign items.payload = q_reg[rp_reg];
    assign push          = tokens.valid && tokens.ready;
    assign pop           = items.valid && items.ready;

    // classes above end of input all behave as the unknown token
    always_comb
    begin
        cls.tok = (tokens.payload.token_class > TOK_EOI) ? TOK_UNKNOWN
                                                         : tokens.payload.token_class;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* hw/rtl/ll1p_back.sv */
// ll1p_back: stack sequencer, one stack operation per cycle, with result register
// depends on ll1p_pkg and ll1p_stream_if; holds the symbol stack memory
module ll1p_back
    import ll1p_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    ll1p_stream_if.sink   items,
    ll1p_stream_if.source results
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_PUSH,
        ST_POPRD,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    sym_t               top_reg;
    tok_t               tok_reg;
    logic [CNT_W-1:0]   errs_reg;
    logic [CNT_W-1:0]   exps_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               matched_reg;
    logic               discarded_reg;
    logic               acc_reg;
    logic               clean_reg;
    logic               ovf_reg;
    logic               finished_reg;
    logic               done_reg;
    logic [6:0]         cell_reg;
    logic               fhit_reg;
    logic [5:0]         prod_reg;
    logic [3:0]         k_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    sym_t               mem [STACK_DEPTH];
    sym_t               rdata_reg;
    logic               we;
    logic [AW-1:0]      waddr;
    sym_t               wdata;
    logic [CW-1:0]      pop_full;
    logic [AW-1:0]      raddr;

    logic [5:0]         nt;
    logic [5:0]         dec_prod;
    rule_t              dec_rule;
    rule_t              push_rule;
    logic [CW:0]        reach;
    logic               take;
    logic [CNT_W-1:0]   errs_inc;
    logic [TOTAL_W-1:0] total_inc;

    assign items.ready     = (state_reg == ST_IDLE) && !out_valid_reg;
    assign take            = items.valid && items.ready;
    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    assign nt        = 6'(top_reg - sym_t'(NT_BASE));
    assign dec_prod  = 6'(cell_reg - 7'd1);
    assign dec_rule  = rule_at(int'(dec_prod));
    assign push_rule = rule_at(int'(prod_reg));
    // stack size after expansion plus one, compared against depth plus one
    assign reach     = {1'b0, count_reg} + (CW+1)'(dec_rule.len);
    assign errs_inc  = (errs_reg == {CNT_W{1'b1}}) ? errs_reg : errs_reg + 1'b1;
    assign total_inc = (total_reg == {TOTAL_W{1'b1}}) ? total_reg : total_reg + 1'b1;

    // new top after a pop sits at count - 2 of the current count
    assign pop_full = count_reg - CW'(2);
    assign raddr    = pop_full[AW-1:0];
    assign we       = (state_reg == ST_PUSH);
    assign waddr    = count_reg[AW-1:0];
    assign wdata    = push_rule.rhs[k_reg - 4'd1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CW'(2);
            top_reg       <= N_PROG;
            total_reg     <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tok_reg       <= '0;
            errs_reg      <= '0;
            exps_reg      <= '0;
            matched_reg   <= 1'b0;
            discarded_reg <= 1'b0;
            acc_reg       <= 1'b0;
            clean_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            done_reg      <= 1'b0;
            cell_reg      <= '0;
            fhit_reg      <= 1'b0;
            prod_reg      <= '0;
            k_reg         <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        tok_reg       <= items.payload.tok;
                        errs_reg      <= '0;
                        exps_reg      <= '0;
                        matched_reg   <= 1'b0;
                        discarded_reg <= 1'b0;
                        acc_reg       <= 1'b0;
                        clean_reg     <= 1'b0;
                        ovf_reg       <= 1'b0;
                        done_reg      <= 1'b0;
                        // once finished every token gets an all-zero result
                        state_reg     <= finished_reg ? ST_EMIT : ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    if (top_reg == T_EOI)
                    begin
                        if (tok_reg == TOK_EOI)
                        begin
                            acc_reg      <= 1'b1;
                            clean_reg    <= (total_reg == '0);
                            finished_reg <= 1'b1;
                        end
                        else
                        begin
                            errs_reg      <= errs_inc;
                            total_reg     <= total_inc;
                            discarded_reg <= 1'b1;
                        end
                        state_reg <= ST_EMIT;
                    end
                    else if (top_reg < sym_t'(NT_BASE))
                    begin
                        count_reg <= count_reg - 1'b1;
                        if (top_reg == {1'b0, tok_reg})
                        begin
                            matched_reg <= 1'b1;
                            done_reg    <= 1'b1;
                        end
                        else
                        begin
                            errs_reg  <= errs_inc;
                            total_reg <= total_inc;
                        end
                        state_reg <= ST_POPRD;
                    end
                    else if (top_reg >= sym_t'(NT_BASE + NT_COUNT))
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= ST_POPRD;
                    end
                    else
                    begin
                        cell_reg  <= (tok_reg < 6'd32) ? PTABLE[nt][tok_reg[4:0]] : 7'd0;
                        fhit_reg  <= (tok_reg == TOK_EOI) ||
                                     ((tok_reg < 6'd32) && FOLLOW_SETS[nt][tok_reg[4:0]]);
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (cell_reg != 7'd0)
                    begin
                        if (reach > (CW+1)'(STACK_DEPTH + 1))
                        begin
                            ovf_reg      <= 1'b1;
                            finished_reg <= 1'b1;
                            state_reg    <= ST_EMIT;
                        end
                        else
                        begin
                            count_reg <= count_reg - 1'b1;
                            exps_reg  <= (exps_reg == {CNT_W{1'b1}}) ? exps_reg
                                                                     : exps_reg + 1'b1;
                            prod_reg  <= dec_prod;
                            k_reg     <= dec_rule.len;
                            state_reg <= (dec_rule.len == 4'd0) ? ST_POPRD : ST_PUSH;
                        end
                    end
                    else if (fhit_reg)
                    begin
                        errs_reg  <= errs_inc;
                        total_reg <= total_inc;
                        count_reg <= count_reg - 1'b1;
                        state_reg <= ST_POPRD;
                    end
                    else
                    begin
                        errs_reg      <= errs_inc;
                        total_reg     <= total_inc;
                        discarded_reg <= 1'b1;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_PUSH:
                begin
                    // right-hand side goes on last symbol first
                    top_reg   <= wdata;
                    count_reg <= count_reg + 1'b1;
                    k_reg     <= k_reg - 4'd1;
                    if (k_reg == 4'd1)
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_POPRD:
                begin
                    // entry zero is never written; the bottom marker comes back at a count of one
                    top_reg   <= (count_reg == CW'(1)) ? T_EOI : rdata_reg;
                    state_reg <= done_reg ? ST_EMIT : ST_LOOK;
                end
                ST_EMIT:
                begin
                    out_valid_reg           <= 1'b1;
                    out_reg.token_matched    <= matched_reg;
                    out_reg.token_discarded  <= discarded_reg;
                    out_reg.errors_added     <= errs_reg;
                    out_reg.expansions_done  <= exps_reg;
                    out_reg.parse_accepted   <= acc_reg;
                    out_reg.parse_clean      <= clean_reg;
                    out_reg.stack_overflowed <= ovf_reg;
                    state_reg               <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for the ll(1) table parser with panic recovery
// depends on ll1p_pkg, ll1p_stream_if and ll1_table_parser_with_recovery_unit
// drives one long random program (with noise) and checks every result transaction
module testbench;
    import ll1p_pkg::*;

    localparam int DEPTH      = 64;
    localparam int ITER_BOUND = 8 * DEPTH + 256;
    localparam int BODY_ITEMS = 1330;
    localparam int CALM_TAIL  = 150;
    localparam int PAUSE_AT   = 600;
    localparam int DRAIN_WAIT = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    ll1p_stream_if #(.payload_t(token_t))  tok_ch ();
    ll1p_stream_if #(.payload_t(result_t)) res_ch ();

    ll1_table_parser_with_recovery_unit #(.STACK_DEPTH(DEPTH)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tokens  (tok_ch),
        .results (res_ch)
    );

    // grammar held by the bench, table built from it independently of the rtl
    sym_t        g_lhs [PROD_COUNT];
    int          g_len [PROD_COUNT];
    sym_t        g_rhs [PROD_COUNT][10];
    logic [32:0] first_of [NT_COUNT];
    logic [32:0] follow_of [NT_COUNT];
    int          table_cell [NT_COUNT][32];
    int          n_prod = 0;

    // parser state mirror
    sym_t        sym_stack [DEPTH];
    int          depth_now;
    int          err_sum;
    bit          parse_done;

    tok_t        pending_tokens [$];
    result_t     expected_results [$];
    int          sent_idx = 0;
    bit          failed = 0;

    // coverage tallies for the summary
    int          n_match = 0, n_discard = 0, n_err_tok = 0, n_zero = 0;
    bit          saw_accept = 0, saw_clean = 0, noise_on = 0;

    task automatic add_production(input sym_t l, input int n,
                                  input sym_t s0 = '0, input sym_t s1 = '0,
                                  input sym_t s2 = '0, input sym_t s3 = '0,
                                  input sym_t s4 = '0, input sym_t s5 = '0,
                                  input sym_t s6 = '0, input sym_t s7 = '0,
                                  input sym_t s8 = '0, input sym_t s9 = '0);
        g_lhs[n_prod] = l;
        g_len[n_prod] = n;
        g_rhs[n_prod] = '{s0, s1, s2, s3, s4, s5, s6, s7, s8, s9};
        n_prod++;
    endtask

    // append one token class to the stimulus queue
    task automatic queue_token(input tok_t t);
        pending_tokens.insert(pending_tokens.size(), t);
    endtask

    // first set of rhs[from..] of one production, bit 32 marks empty
    function automatic logic [32:0] rhs_first(int p, int from);
        logic [32:0] acc;
        int          s;
        acc = '0;
        for (int i = from; i < g_len[p]; i++)
        begin
            s = int'(g_rhs[p][i]);
            if (s < NT_BASE)
                return acc | (33'd1 << s);
            acc |= first_of[s - NT_BASE] & ~(33'd1 << 32);
            if (!first_of[s - NT_BASE][32])
                return acc;
        end
        return acc | (33'd1 << 32);
    endfunction

    task automatic build_grammar_table();
        bit          changed;
        int          l, s;
        logic [32:0] nv, fb, f;
        add_production(N_PROG, 10, T_KPROG, T_IDENT, T_LPAR, N_IDL, T_RPAR, T_SEMI,
                       N_DECLS, N_SUBS, N_COMP, T_PERIOD);
        add_production(N_IDL, 2, T_IDENT, N_IDLT);
        add_production(N_IDLT, 3, T_COMMA, T_IDENT, N_IDLT);
        add_production(N_IDLT, 0);
        add_production(N_DECLS, 3, T_KVAR, N_DL, N_DECLS);
        add_production(N_DECLS, 0);
        add_production(N_DL, 6, T_IDENT, N_IDLT, T_COLON, N_TYPE, T_SEMI, N_DLT);
        add_production(N_DLT, 6, T_IDENT, N_IDLT, T_COLON, N_TYPE, T_SEMI, N_DLT);
        add_production(N_DLT, 0);
        add_production(N_TYPE, 1, N_STD);
        add_production(N_TYPE, 8, T_KARRAY, T_LBRK, T_NUMBER, T_RANGE, T_NUMBER,
                       T_RBRK, T_KOF, N_STD);
        add_production(N_STD, 1, T_KINT);
        add_production(N_STD, 1, T_KREAL);
        add_production(N_SUBS, 3, N_SUB, T_SEMI, N_SUBS);
        add_production(N_SUBS, 0);
        add_production(N_SUB, 3, N_SHEAD, N_DECLS, N_COMP);
        add_production(N_SHEAD, 6, T_KFUNC, T_IDENT, N_ARGS, T_COLON, N_STD, T_SEMI);
        add_production(N_SHEAD, 4, T_KPROC, T_IDENT, N_ARGS, T_SEMI);
        add_production(N_ARGS, 3, T_LPAR, N_PL, T_RPAR);
        add_production(N_ARGS, 0);
        add_production(N_PL, 4, N_IDL, T_COLON, N_TYPE, N_PT);
        add_production(N_PT, 5, T_SEMI, N_IDL, T_COLON, N_TYPE, N_PT);
        add_production(N_PT, 0);
        add_production(N_COMP, 3, T_KBEGIN, N_OPTS, T_KEND);
        add_production(N_OPTS, 1, N_SL);
        add_production(N_OPTS, 0);
        add_production(N_SL, 2, N_STMT, N_SLT);
        add_production(N_SLT, 2, T_SEMI, N_SLTS);
        add_production(N_SLT, 0);
        add_production(N_SLTS, 2, N_STMT, N_SLT);
        add_production(N_SLTS, 0);
        add_production(N_STMT, 2, T_IDENT, N_SIT);
        add_production(N_STMT, 1, N_COMP);
        add_production(N_STMT, 5, T_KIF, N_EXPR, T_KTHEN, N_STMT, N_ELSE);
        add_production(N_STMT, 4, T_KWHILE, N_EXPR, T_KDO, N_STMT);
        add_production(N_STMT, 0);
        add_production(N_SIT, 2, T_ASSIGN, N_EXPR);
        add_production(N_SIT, 5, T_LBRK, N_EXPR, T_RBRK, T_ASSIGN, N_EXPR);
        add_production(N_SIT, 3, T_LPAR, N_ELO, T_RPAR);
        add_production(N_SIT, 0);
        add_production(N_ELSE, 2, T_KELSE, N_STMT);
        add_production(N_ELSE, 0);
        add_production(N_ELO, 1, N_EL);
        add_production(N_ELO, 0);
        add_production(N_EL, 2, N_EXPR, N_ELT);
        add_production(N_ELT, 3, T_COMMA, N_EXPR, N_ELT);
        add_production(N_ELT, 0);
        add_production(N_EXPR, 2, N_SIMP, N_EXT);
        add_production(N_EXT, 2, T_REL, N_SIMP);
        add_production(N_EXT, 0);
        add_production(N_SIMP, 3, T_ADD, N_TERM, N_SIMT);
        add_production(N_SIMP, 2, N_TERM, N_SIMT);
        add_production(N_SIMT, 3, T_ADD, N_TERM, N_SIMT);
        add_production(N_SIMT, 0);
        add_production(N_TERM, 2, N_FACT, N_TERMT);
        add_production(N_TERMT, 3, T_MUL, N_FACT, N_TERMT);
        add_production(N_TERMT, 0);
        add_production(N_FACT, 2, T_IDENT, N_FIT);
        add_production(N_FACT, 1, T_NUMBER);
        add_production(N_FACT, 3, T_LPAR, N_EXPR, T_RPAR);
        add_production(N_FACT, 2, T_KNOT, N_FACT);
        add_production(N_FIT, 3, T_LPAR, N_ELO, T_RPAR);
        add_production(N_FIT, 3, T_LBRK, N_EXPR, T_RBRK);
        add_production(N_FIT, 0);

        foreach (first_of[i])
        begin
            first_of[i] = '0;
            follow_of[i] = '0;
            for (int t = 0; t < 32; t++)
                table_cell[i][t] = 0;
        end
        changed = 1;
        while (changed)
        begin
            changed = 0;
            for (int p = 0; p < PROD_COUNT; p++)
            begin
                l = int'(g_lhs[p]) - NT_BASE;
                nv = first_of[l] | rhs_first(p, 0);
                if (nv != first_of[l])
                begin
                    first_of[l] = nv;
                    changed = 1;
                end
            end
        end
        follow_of[0] = 33'd1 << int'(T_EOI);
        changed = 1;
        while (changed)
        begin
            changed = 0;
            for (int p = 0; p < PROD_COUNT; p++)
            begin
                l = int'(g_lhs[p]) - NT_BASE;
                for (int i = 0; i < g_len[p]; i++)
                begin
                    s = int'(g_rhs[p][i]);
                    if (s >= NT_BASE)
                    begin
                        fb = rhs_first(p, i + 1);
                        nv = follow_of[s - NT_BASE] | (fb & ~(33'd1 << 32));
                        if (fb[32])
                            nv |= follow_of[l];
                        if (nv != follow_of[s - NT_BASE])
                        begin
                            follow_of[s - NT_BASE] = nv;
                            changed = 1;
                        end
                    end
                end
            end
        end
        // first entries overwrite, follow entries only fill empty cells
        for (int p = 0; p < PROD_COUNT; p++)
        begin
            l = int'(g_lhs[p]) - NT_BASE;
            f = rhs_first(p, 0);
            for (int t = 0; t < 32; t++)
                if (f[t])
                    table_cell[l][t] = p + 1;
            if (f[32])
                for (int t = 0; t < 32; t++)
                    if (follow_of[l][t] && table_cell[l][t] == 0)
                        table_cell[l][t] = p + 1;
        end
    endtask

    function automatic void raise_error(inout int errs);
        if (errs < 63)
            errs++;
        if (err_sum < 65535)
            err_sum++;
    endfunction

    // predicted result for one token; advances the mirrored parser state
    function automatic result_t parse_token(tok_t cls);
        result_t r;
        int      tok, top, nt, entry, p, errs, exps;
        r = '0;
        errs = 0;
        exps = 0;
        tok = (cls > 6'd31) ? 32 : int'(cls);
        for (int iter = 0; !parse_done && iter < ITER_BOUND; iter++)
        begin
            top = (depth_now > 0 && depth_now <= DEPTH) ? int'(sym_stack[depth_now - 1])
                                                       : int'(T_EOI);
            if (top == int'(T_EOI))
            begin
                if (tok == int'(T_EOI))
                begin
                    r.parse_accepted = 1'b1;
                    r.parse_clean = (err_sum == 0);
                    parse_done = 1;
                end
                else
                begin
                    // extra token once the stack is back at the bottom marker
                    raise_error(errs);
                    r.token_discarded = 1'b1;
                end
                break;
            end
            if (top < NT_BASE)
            begin
                if (depth_now > 1)
                    depth_now--;
                if (top == tok)
                begin
                    r.token_matched = 1'b1;
                    break;
                end
                raise_error(errs);
                continue;
            end
            nt = top - NT_BASE;
            if (nt >= NT_COUNT)
            begin
                if (depth_now > 1)
                    depth_now--;
                continue;
            end
            entry = (tok < 32) ? table_cell[nt][tok] : 0;
            if (entry != 0)
            begin
                p = entry - 1;
                if (depth_now - 1 + g_len[p] > DEPTH)
                begin
                    r.stack_overflowed = 1'b1;
                    parse_done = 1;
                    break;
                end
                depth_now--;
                for (int k = g_len[p]; k > 0; k--)
                begin
                    sym_stack[depth_now] = g_rhs[p][k - 1];
                    depth_now++;
                end
                if (exps < 63)
                    exps++;
                continue;
            end
            if (tok == int'(T_EOI) || (tok < 32 && follow_of[nt][tok]))
            begin
                raise_error(errs);
                if (depth_now > 1)
                    depth_now--;
                continue;
            end
            raise_error(errs);
            r.token_discarded = 1'b1;
            break;
        end
        r.errors_added = CNT_W'(errs);
        r.expansions_done = CNT_W'(exps);
        return r;
    endfunction

    // ---------------- token generation ----------------

    // queue a token, with occasional noise (never end of input) while enabled
    task automatic emit(input sym_t s);
        int v;
        queue_token(tok_t'(s));
        if (noise_on && $urandom_range(0, 29) == 0)
        begin
            v = $urandom_range(0, 62);
            if (v == int'(TOK_EOI))
                v = 63;
            queue_token(tok_t'(v));
        end
    endtask

    task automatic gen_expr(input int lvl);
        gen_simple(lvl);
        if ($urandom_range(0, 2) == 0)
        begin
            emit(T_REL);
            gen_simple(lvl);
        end
    endtask

    task automatic gen_simple(input int lvl);
        if ($urandom_range(0, 3) == 0)
            emit(T_ADD);
        gen_term(lvl);
        for (int i = 0; i < 2 && $urandom_range(0, 2) == 0; i++)
        begin
            emit(T_ADD);
            gen_term(lvl);
        end
    endtask

    task automatic gen_term(input int lvl);
        gen_factor(lvl);
        for (int i = 0; i < 2 && $urandom_range(0, 2) == 0; i++)
        begin
            emit(T_MUL);
            gen_factor(lvl);
        end
    endtask

    task automatic gen_factor(input int lvl);
        int pick;
        pick = (lvl >= 2) ? $urandom_range(0, 1) : $urandom_range(0, 5);
        case (pick)
            0: emit(T_IDENT);
            1: emit(T_NUMBER);
            2:
            begin
                emit(T_IDENT);
                emit(T_LBRK);
                gen_expr(lvl + 1);
                emit(T_RBRK);
            end
            3:
            begin
                emit(T_IDENT);
                emit(T_LPAR);
                gen_expr(lvl + 1);
                if ($urandom_range(0, 1) == 0)
                begin
                    emit(T_COMMA);
                    gen_expr(lvl + 1);
                end
                emit(T_RPAR);
            end
            4:
            begin
                emit(T_LPAR);
                gen_expr(lvl + 1);
                emit(T_RPAR);
            end
            default:
            begin
                emit(T_KNOT);
                gen_factor(lvl + 1);
            end
        endcase
    endtask

    task automatic gen_stmt(input int lvl);
        int pick;
        pick = (lvl >= 2) ? $urandom_range(0, 2) : $urandom_range(0, 6);
        case (pick)
            0:
            begin
                emit(T_IDENT);
                emit(T_ASSIGN);
                gen_expr(lvl);
            end
            1:
            begin
                emit(T_IDENT);
                emit(T_LBRK);
                gen_expr(lvl);
                emit(T_RBRK);
                emit(T_ASSIGN);
                gen_expr(lvl);
            end
            2:
            begin
                emit(T_IDENT);
                if ($urandom_range(0, 1) == 0)
                begin
                    emit(T_LPAR);
                    gen_expr(lvl);
                    emit(T_RPAR);
                end
            end
            3:
            begin
                emit(T_KBEGIN);
                gen_stmt(lvl + 1);
                for (int i = 0; i < 2 && $urandom_range(0, 1) == 0; i++)
                begin
                    emit(T_SEMI);
                    gen_stmt(lvl + 1);
                end
                emit(T_KEND);
            end
            4:
            begin
                emit(T_KIF);
                gen_expr(lvl);
                emit(T_KTHEN);
                gen_stmt(lvl + 1);
                if ($urandom_range(0, 1) == 0)
                begin
                    emit(T_KELSE);
                    gen_stmt(lvl + 1);
                end
            end
            5:
            begin
                emit(T_KWHILE);
                gen_expr(lvl);
                emit(T_KDO);
                gen_stmt(lvl + 1);
            end
            default: ;
        endcase
    endtask

    initial
    begin
        sym_t header [] = '{T_KPROG, T_IDENT, T_LPAR, T_IDENT, T_COMMA, T_IDENT, T_RPAR,
                            T_SEMI, T_KVAR, T_IDENT, T_COLON, T_KINT, T_SEMI, T_IDENT,
                            T_COLON, T_KARRAY, T_LBRK, T_NUMBER, T_RANGE, T_NUMBER,
                            T_RBRK, T_KOF, T_KREAL, T_SEMI, T_KPROC, T_IDENT, T_LPAR,
                            T_IDENT, T_COLON, T_KINT, T_RPAR, T_SEMI, T_KBEGIN, T_KEND,
                            T_SEMI, T_KFUNC, T_IDENT, T_COLON, T_KREAL, T_SEMI,
                            T_KBEGIN, T_KEND, T_SEMI, T_KBEGIN};
        build_grammar_table();
        sym_stack[0] = T_EOI;
        sym_stack[1] = N_PROG;
        for (int i = 2; i < DEPTH; i++)
            sym_stack[i] = '0;
        depth_now = 2;
        err_sum = 0;
        parse_done = 0;

        // directed opening: declarations, both subprogram kinds, into the main block
        foreach (header[i])
            emit(header[i]);
        // unknown classes at both ends of the unknown range, then recovery
        queue_token(TOK_UNKNOWN);
        queue_token(tok_t'(63));
        emit(T_IDENT);
        emit(T_ASSIGN);
        emit(T_KNOT);
        emit(T_NUMBER);
        emit(T_SEMI);

        // random body: well-formed statements with sparse noise
        noise_on = 1;
        while (pending_tokens.size() < BODY_ITEMS)
        begin
            gen_stmt(0);
            emit(T_SEMI);
        end
        noise_on = 0;
        emit(T_KEND);
        emit(T_PERIOD);
        // extra tokens after the program end, then accept, then dead tokens
        emit(T_IDENT);
        queue_token(TOK_UNKNOWN);
        queue_token(TOK_EOI);
        emit(T_RANGE);
        emit(T_NUMBER);
        queue_token(TOK_EOI);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------- token driver ----------------
    int send_gap = 0;
    bit paused_once = 0;

    always @(posedge clk or negedge rst_n)
    begin
        bit go;
        bit hold;
        if (!rst_n)
        begin
            tok_ch.valid <= 1'b0;
            tok_ch.payload <= '0;
            send_gap = 0;
        end
        else
        begin
            // an offered token stays on the channel until it is taken
            hold = tok_ch.valid && !tok_ch.ready;
            if (tok_ch.valid && tok_ch.ready)
            begin
                expected_results.insert(expected_results.size(),
                                        parse_token(pending_tokens[sent_idx]));
                sent_idx++;
            end
            if (send_gap > 0)
                send_gap--;
            else if (!hold && sent_idx < pending_tokens.size() - CALM_TAIL
                     && $urandom_range(0, 15) == 0)
                send_gap = $urandom_range(1, 15);
            // one drain pause midway: hold off until every result is back
            if (!paused_once && sent_idx == PAUSE_AT && expected_results.size() == 0)
                paused_once = 1;
            go = hold || (sent_idx < pending_tokens.size() && send_gap == 0
                          && !(sent_idx == PAUSE_AT && !paused_once));
            tok_ch.valid <= go;
            if (go)
                tok_ch.payload <= pending_tokens[sent_idx];
        end
    end

    // ---------------- result monitor ----------------
    int recv_gap = 0;

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, fname, want, got);
            failed = 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want, got;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.payload;
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result transaction %h", $time, got);
                    failed = 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("token_matched", want.token_matched, got.token_matched);
                    check_field("token_discarded", want.token_discarded,
                                got.token_discarded);
                    check_field("errors_added", want.errors_added, got.errors_added);
                    check_field("expansions_done", want.expansions_done,
                                got.expansions_done);
                    check_field("parse_accepted", want.parse_accepted, got.parse_accepted);
                    check_field("parse_clean", want.parse_clean, got.parse_clean);
                    check_field("stack_overflowed", want.stack_overflowed,
                                got.stack_overflowed);
                    n_match += want.token_matched;
                    n_discard += want.token_discarded;
                    n_err_tok += (want.errors_added != 0);
                    n_zero += (want == '0);
                    saw_accept |= want.parse_accepted;
                    saw_clean |= want.parse_clean;
                end
            end
            if (recv_gap > 0)
                recv_gap--;
            else if (sent_idx < pending_tokens.size() - CALM_TAIL
                     && $urandom_range(0, 15) == 0)
                recv_gap = $urandom_range(1, 15);
            res_ch.ready <= (recv_gap == 0);
        end
    end

    // ---------------- end of run ----------------
    initial
    begin
        wait (rst_n === 1'b1);
        wait (sent_idx == pending_tokens.size() && expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t %0d results never arrived", $time, expected_results.size());
            failed = 1;
        end
        $display("covered %0d tokens: %0d matched, %0d discarded, %0d with errors",
                 pending_tokens.size(), n_match, n_discard, n_err_tok);
        $display("parse accepted %0d (clean %0d), %0d all-zero results after finish",
                 saw_accept, saw_clean, n_zero);
        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
